[sv/kmhrb_pkg.sv]
package kmhrb_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] CMD_STORE_MASK  = 2'd1;
  localparam logic [1:0] CMD_BUILD       = 2'd2;

  // Keymap entry types.
  localparam logic [1:0] TYPE_OTHER  = 2'd0;
  localparam logic [1:0] TYPE_HID    = 2'd1;
  localparam logic [1:0] TYPE_MOD    = 2'd2;
  localparam logic [1:0] TYPE_HIDMOD = 2'd3;

  // Width of a row mask; columns at or above it are never pressed.
  localparam int unsigned MASK_BITS = 14;

  // HID keycode reported in slot 0 when too many keys are down.
  localparam logic [7:0] ROLLOVER_CODE = 8'h01;

  localparam logic [3:0] KEY_LIMIT_RESET = 4'd6;

  // Keymap entry: type in the two upper bits, data below.
  localparam int unsigned ENTRY_BITS = 18;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  row_index;
    logic [3:0]  col_index;
    logic [1:0]  entry_type;
    logic [15:0] entry_data;
    logic [13:0] row_mask;
  } in_item_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic [7:0] keycode;
    logic [7:0] modifier;
    logic       rollover;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT,
    ST_FLUSH
  } state_t;

endpackage

[sv/keymap_hid_report_builder.sv]
// Keyboard report builder with a stored keymap and per-row pressed masks.
//
// Input channel: a transaction is taken on a rising edge with start high and
// busy low. Command 0 writes one keymap entry and command 1 stores the pressed
// mask of one row; both leave busy low, so they can follow each other on
// every cycle. Command 2 builds a keyboard report. Writes outside the matrix
// are dropped, and command 3 does nothing.
//
// A build walks the keymap memory in row-major order, one entry read per
// cycle, then reads the slots back one per cycle. busy stays high from the
// accepting edge through the walk and the slot reads, so a new build is only
// accepted once the previous one has read out its slots. The slot results
// follow on consecutive cycles, each shown for one cycle with out_valid
// high and last set on the final slot. The receiver cannot stall.
// Configuration channel: cfg_ready is always high; cfg_data sets the keycode
// count at or above which the report becomes a rollover error.
// Reset clears the row masks, the count and the modifier and sets the
// threshold to 6. Keymap entries hold nothing until written.
module keymap_hid_report_builder #(
  parameter int unsigned NUM_ROWS  = 5,
  parameter int unsigned NUM_COLS  = 14,
  parameter int unsigned NUM_SLOTS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  kmhrb_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output kmhrb_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data
);

  localparam int unsigned KM_DEPTH = NUM_ROWS * NUM_COLS;
  localparam int unsigned KAW = (KM_DEPTH > 1) ? $clog2(KM_DEPTH) : 1;
  localparam int unsigned SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [3:0] key_limit_r;

  logic                               km_we;
  logic [KAW-1:0]                     km_waddr;
  logic [kmhrb_pkg::ENTRY_BITS-1:0]   km_wdata;
  logic [KAW-1:0]                     km_raddr;
  logic [kmhrb_pkg::ENTRY_BITS-1:0]   km_rdata;
  logic                               slot_we;
  logic [SW-1:0]                      slot_waddr;
  logic [7:0]                         slot_wdata;
  logic [SW-1:0]                      slot_raddr;
  logic [7:0]                         slot_rdata;

  // The threshold register accepts a write on every cycle; the user must change
  // it only while no build is running, as the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= kmhrb_pkg::KEY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_limit_r <= cfg_data;
    end
  end

  // Keymap: one entry per matrix position, type and data packed together.
  kmhrb_ram #(
    .WIDTH (kmhrb_pkg::ENTRY_BITS),
    .DEPTH (KM_DEPTH)
  ) u_keymap (
    .clk   (clk),
    .we    (km_we),
    .waddr (km_waddr),
    .wdata (km_wdata),
    .raddr (km_raddr),
    .rdata (km_rdata)
  );

  // Report slots. Only slots below the fill count are meaningful, so the
  // memory never needs clearing between reports.
  kmhrb_ram #(
    .WIDTH (8),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  kmhrb_ctrl #(
    .NUM_ROWS  (NUM_ROWS),
    .NUM_COLS  (NUM_COLS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .key_limit    (key_limit_r),
    .km_we        (km_we),
    .km_waddr     (km_waddr),
    .km_wdata     (km_wdata),
    .km_raddr     (km_raddr),
    .km_rdata     (km_rdata),
    .slot_we      (slot_we),
    .slot_waddr   (slot_waddr),
    .slot_wdata   (slot_wdata),
    .slot_raddr   (slot_raddr),
    .slot_rdata   (slot_rdata),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

[sv/kmhrb_ram.sv]
module kmhrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/kmhrb_ctrl.sv]
module kmhrb_ctrl #(
  parameter int unsigned NUM_ROWS  = 5,
  parameter int unsigned NUM_COLS  = 14,
  parameter int unsigned NUM_SLOTS = 14,
  localparam int unsigned KM_DEPTH = NUM_ROWS * NUM_COLS,
  localparam int unsigned KAW  = (KM_DEPTH > 1) ? $clog2(KM_DEPTH) : 1,
  localparam int unsigned SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  kmhrb_pkg::in_item_t                 in_item,
  input  logic [3:0]                          key_limit,
  output logic                                km_we,
  output logic [KAW-1:0]                      km_waddr,
  output logic [kmhrb_pkg::ENTRY_BITS-1:0]    km_wdata,
  output logic [KAW-1:0]                      km_raddr,
  input  logic [kmhrb_pkg::ENTRY_BITS-1:0]    km_rdata,
  output logic                                slot_we,
  output logic [SW-1:0]                       slot_waddr,
  output logic [7:0]                          slot_wdata,
  output logic [SW-1:0]                       slot_raddr,
  input  logic [7:0]                          slot_rdata,
  output logic                                out_valid,
  output kmhrb_pkg::out_item_t                out_item
);

  localparam int unsigned RW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned CW   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int unsigned CNTW = $clog2(NUM_SLOTS + 1);

  kmhrb_pkg::state_t state_r, state_nxt;

  logic [13:0]     row_masks_r [NUM_ROWS];
  logic [RW-1:0]   row_r, row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [KAW-1:0]  addr_r, addr_nxt;
  logic            walk_vld_r, walk_vld_nxt;
  logic            pressed_r, pressed_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [7:0]      mod_r, mod_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic            em_vld_r, em_vld_nxt;
  logic [SW-1:0]   em_idx_r, em_idx_nxt;
  logic            out_valid_r;
  kmhrb_pkg::out_item_t out_r, out_nxt;

  logic            accept;
  logic            walk_last;
  logic            emit_last;
  logic [31:0]     mask_wide;
  logic [NUM_COLS-1:0] col_pressed;
  logic            row_ok;
  logic            col_ok;
  logic [RW-1:0]   wr_row;
  logic [1:0]      ent_type;
  logic [15:0]     ent_data;
  logic            roll;
  logic            in_fill;
  logic            app_en;
  logic [7:0]      app_code;

  assign accept    = start && (state_r == kmhrb_pkg::ST_IDLE);
  assign walk_last = (row_r == RW'(NUM_ROWS - 1)) && (col_r == CW'(NUM_COLS - 1));
  assign emit_last = (slot_r == SW'(NUM_SLOTS - 1));
  assign row_ok    = int'(in_item.row_index) < NUM_ROWS;
  assign col_ok    = int'(in_item.col_index) < NUM_COLS;
  assign wr_row    = RW'(in_item.row_index);
  assign ent_type  = km_rdata[kmhrb_pkg::ENTRY_BITS-1 -: 2];
  assign ent_data  = km_rdata[15:0];

  // Pressed bits of the row being walked, widened to the column count.
  always_comb begin
    mask_wide = 32'(row_masks_r[row_r]);
    for (int c = 0; c < NUM_COLS; c++) begin
      col_pressed[c] = (c < kmhrb_pkg::MASK_BITS) ? mask_wide[c] : 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kmhrb_pkg::ST_IDLE: begin
        if (accept && in_item.cmd == kmhrb_pkg::CMD_BUILD) begin
          state_nxt = kmhrb_pkg::ST_WALK;
        end
      end
      kmhrb_pkg::ST_WALK: begin
        if (walk_last) begin
          state_nxt = kmhrb_pkg::ST_DRAIN;
        end
      end
      kmhrb_pkg::ST_DRAIN: state_nxt = kmhrb_pkg::ST_EMIT;
      kmhrb_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_nxt = kmhrb_pkg::ST_FLUSH;
        end
      end
      kmhrb_pkg::ST_FLUSH: state_nxt = kmhrb_pkg::ST_IDLE;
      default: state_nxt = kmhrb_pkg::ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    busy  = 1'b1;
    km_we = 1'b0;
    unique case (state_r) inside
      kmhrb_pkg::ST_IDLE: begin
        busy  = 1'b0;
        km_we = accept && (in_item.cmd == kmhrb_pkg::CMD_WRITE_ENTRY) && row_ok && col_ok;
      end
      kmhrb_pkg::ST_WALK,
      kmhrb_pkg::ST_DRAIN,
      kmhrb_pkg::ST_EMIT,
      kmhrb_pkg::ST_FLUSH: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign km_waddr = KAW'(in_item.row_index) * KAW'(NUM_COLS) + KAW'(in_item.col_index);
  assign km_wdata = {in_item.entry_type, in_item.entry_data};
  assign km_raddr = addr_r;
  assign slot_raddr = slot_r;

  // Entry stage: the keymap read data pairs with the pressed bit of the
  // previous cycle.
  always_comb begin
    app_en   = 1'b0;
    app_code = 8'h00;
    mod_nxt  = mod_r;
    if (walk_vld_r && pressed_r) begin
      case (ent_type)
        kmhrb_pkg::TYPE_HID: begin
          app_en   = 1'b1;
          app_code = ent_data[7:0];
        end
        kmhrb_pkg::TYPE_MOD: mod_nxt = mod_r | ent_data[7:0];
        kmhrb_pkg::TYPE_HIDMOD: begin
          app_en   = 1'b1;
          app_code = ent_data[15:8];
          mod_nxt  = mod_r | ent_data[7:0];
        end
        default: app_en = 1'b0;
      endcase
    end
  end

  assign slot_we    = app_en && (int'(count_r) < NUM_SLOTS);
  assign slot_waddr = count_r[SW-1:0];
  assign slot_wdata = app_code;

  // Walk and emit counters.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    addr_nxt     = addr_r;
    walk_vld_nxt = 1'b0;
    pressed_nxt  = 1'b0;
    count_nxt    = slot_we ? count_r + CNTW'(1) : count_r;
    slot_nxt     = slot_r;
    em_vld_nxt   = 1'b0;
    em_idx_nxt   = slot_r;
    if (accept && in_item.cmd == kmhrb_pkg::CMD_BUILD) begin
      row_nxt   = '0;
      col_nxt   = '0;
      addr_nxt  = '0;
      count_nxt = '0;
    end
    if (state_r == kmhrb_pkg::ST_WALK) begin
      walk_vld_nxt = 1'b1;
      pressed_nxt  = col_pressed[col_r];
      addr_nxt     = addr_r + KAW'(1);
      if (col_r == CW'(NUM_COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (state_r == kmhrb_pkg::ST_DRAIN) begin
      slot_nxt = '0;
    end
    if (state_r == kmhrb_pkg::ST_EMIT) begin
      em_vld_nxt = 1'b1;
      slot_nxt   = slot_r + SW'(1);
    end
  end

  // Result formatting from the slot read data.
  always_comb begin
    roll    = (4'(count_r) >= key_limit);
    in_fill = (CNTW'(em_idx_r) < count_r);
    out_nxt.slot_index = 4'(em_idx_r);
    out_nxt.modifier   = mod_r;
    out_nxt.rollover   = roll;
    out_nxt.last       = (em_idx_r == SW'(NUM_SLOTS - 1));
    if (roll) begin
      out_nxt.keycode = (em_idx_r == '0) ? kmhrb_pkg::ROLLOVER_CODE : 8'h00;
    end else begin
      out_nxt.keycode = in_fill ? slot_rdata : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmhrb_pkg::ST_IDLE;
      walk_vld_r  <= 1'b0;
      em_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      mod_r       <= '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        row_masks_r[r] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      walk_vld_r  <= walk_vld_nxt;
      em_vld_r    <= em_vld_nxt;
      out_valid_r <= em_vld_r;
      count_r     <= count_nxt;
      if (accept && in_item.cmd == kmhrb_pkg::CMD_BUILD) begin
        mod_r <= '0;
      end else begin
        mod_r <= mod_nxt;
      end
      if (accept && in_item.cmd == kmhrb_pkg::CMD_STORE_MASK && row_ok) begin
        row_masks_r[wr_row] <= in_item.row_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    addr_r    <= addr_nxt;
    pressed_r <= pressed_nxt;
    slot_r    <= slot_nxt;
    em_idx_r  <= em_idx_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[tb/keymap_hid_report_builder_tb.sv]
module keymap_hid_report_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Matrix and report sizes of the instance under test.
  localparam int NUM_ROWS  = 5;
  localparam int NUM_COLS  = 14;
  localparam int NUM_SLOTS = 14;

  // The fourth command code is unused by the block and must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // A build keeps busy high for the full keymap walk plus the slot read-out.
  // After the last result the checker keeps watching this long for strays.
  localparam int BUILD_CYCLES  = NUM_ROWS * NUM_COLS + NUM_SLOTS + 2;
  localparam int TAIL_CYCLES   = BUILD_CYCLES + 4;
  // Short settle time before a threshold write once all reports are in.
  localparam int SETTLE_CYCLES = 4;

  // The directed tests send about a hundred transactions; random traffic
  // brings the run to roughly 410.
  localparam int RANDOM_ITEMS = 308;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  kmhrb_pkg::in_item_t  in_item;
  logic                 out_valid;
  kmhrb_pkg::out_item_t out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [3:0]           cfg_data;

  keymap_hid_report_builder #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS),
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the block's state, updated as each transaction is accepted.
  logic [17:0] keymap_shadow [NUM_ROWS * NUM_COLS];
  logic [13:0] row_masks     [NUM_ROWS];
  logic [3:0]  rollover_limit;

  // Slot results still owed by the block, oldest first.
  kmhrb_pkg::out_item_t pending_slots [$];

  int error_count;
  int random_sent;
  bit no_gaps;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // Every input is known from time zero; after that everything is driven
  // with nonblocking assignments right after a rising edge.
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    error_count = 0;
    random_sent = 0;
    no_gaps     = 1'b0;
  end

  // Predicts the effect of one accepted transaction. Entry writes and mask
  // stores update the shadow state; a build walks the pressed keys in
  // row-major order and queues the fourteen slot results it must produce.
  function automatic void apply_command(kmhrb_pkg::in_item_t it);
    logic [7:0]  slots [NUM_SLOTS];
    int          count;
    logic [7:0]  mods;
    logic [17:0] entry;
    bit          roll;
    kmhrb_pkg::out_item_t res;

    case (it.cmd)
      kmhrb_pkg::CMD_WRITE_ENTRY: begin
        if (it.row_index < NUM_ROWS && it.col_index < NUM_COLS)
          keymap_shadow[it.row_index * NUM_COLS + it.col_index] =
            {it.entry_type, it.entry_data};
      end
      kmhrb_pkg::CMD_STORE_MASK: begin
        if (it.row_index < NUM_ROWS)
          row_masks[it.row_index] = it.row_mask;
      end
      kmhrb_pkg::CMD_BUILD: begin
        foreach (slots[i]) slots[i] = '0;
        count = 0;
        mods  = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
          for (int c = 0; c < NUM_COLS; c++) begin
            if (c >= kmhrb_pkg::MASK_BITS || !row_masks[r][c])
              continue;
            entry = keymap_shadow[r * NUM_COLS + c];
            case (entry[17:16])
              kmhrb_pkg::TYPE_HID: begin
                if (count < NUM_SLOTS) begin
                  slots[count] = entry[7:0];
                  count++;
                end
              end
              kmhrb_pkg::TYPE_MOD: mods |= entry[7:0];
              kmhrb_pkg::TYPE_HIDMOD: begin
                // The modifier still counts once the slots are full.
                if (count < NUM_SLOTS) begin
                  slots[count] = entry[15:8];
                  count++;
                end
                mods |= entry[7:0];
              end
              default: ;
            endcase
          end
        end
        // Too many keys: the slots are replaced by the error code, but the
        // modifier is reported as built.
        roll = (count >= rollover_limit);
        if (roll) begin
          foreach (slots[i]) slots[i] = '0;
          slots[0] = kmhrb_pkg::ROLLOVER_CODE;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
          res.slot_index = 4'(k);
          res.keycode    = slots[k];
          res.modifier   = mods;
          res.rollover   = roll;
          res.last       = (k == NUM_SLOTS - 1);
          pending_slots.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  // Every input field gets random content; callers override what matters.
  function automatic kmhrb_pkg::in_item_t random_fields();
    kmhrb_pkg::in_item_t it;
    it.cmd        = 2'($urandom);
    it.row_index  = 3'($urandom);
    it.col_index  = 4'($urandom);
    it.entry_type = 2'($urandom);
    it.entry_data = 16'($urandom);
    it.row_mask   = 14'($urandom);
    return it;
  endfunction

  function automatic kmhrb_pkg::in_item_t entry_item(int row, int col, logic [1:0] kind,
                                                     logic [15:0] data);
    kmhrb_pkg::in_item_t it;
    it            = random_fields();
    it.cmd        = kmhrb_pkg::CMD_WRITE_ENTRY;
    it.row_index  = 3'(row);
    it.col_index  = 4'(col);
    it.entry_type = kind;
    it.entry_data = data;
    return it;
  endfunction

  function automatic kmhrb_pkg::in_item_t mask_item(int row, logic [13:0] mask);
    kmhrb_pkg::in_item_t it;
    it           = random_fields();
    it.cmd       = kmhrb_pkg::CMD_STORE_MASK;
    it.row_index = 3'(row);
    it.row_mask  = mask;
    return it;
  endfunction

  function automatic kmhrb_pkg::in_item_t build_item();
    kmhrb_pkg::in_item_t it;
    it     = random_fields();
    it.cmd = kmhrb_pkg::CMD_BUILD;
    return it;
  endfunction

  // Mostly sparse masks so the keycode count lands near the threshold, with
  // some empty, dense and fully pressed rows mixed in.
  function automatic logic [13:0] pick_mask();
    logic [13:0] m;
    m = '0;
    case ($urandom_range(0, 5))
      0:       m = '0;
      1:       m = 14'($urandom);
      2:       m = '1;
      default: repeat ($urandom_range(1, 3))
                 m[$urandom_range(0, kmhrb_pkg::MASK_BITS - 1)] = 1'b1;
    endcase
    return m;
  endfunction

  // Presents one transaction and holds it until the block takes it. start is
  // left high so a following transaction can go out on the very next cycle;
  // anything that waits must drop start first.
  task automatic send_item(input kmhrb_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(it);
  endtask

  // Random sender gap, switched off near the end.
  task automatic sender_gap();
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed slot result has arrived and the
  // block is idle again.
  task automatic wait_reports_done();
    start <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Threshold write on the configuration channel; only called while idle.
  task automatic set_rollover_limit(input logic [3:0] value);
    wait_reports_done();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rollover_limit = value;
    cfg_valid     <= 1'b0;
  endtask

  // Every keymap entry is written before any key can be pressed, so a build
  // never looks at an entry that holds nothing.
  task automatic test_keymap_fill();
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        send_item(entry_item(r, c, 2'($urandom_range(0, 3)), 16'($urandom)));
        sender_gap();
      end
    end
  endtask

  // One key of each type in row 0, another at the last row and column with all-ones
  // data, then a build that should show three keycodes and the ORed modifier.
  task automatic test_entry_types();
    send_item(entry_item(0, 0, kmhrb_pkg::TYPE_HID, 16'h0004));
    send_item(entry_item(0, 1, kmhrb_pkg::TYPE_MOD, 16'h0000));
    sender_gap();
    send_item(entry_item(0, 2, kmhrb_pkg::TYPE_HIDMOD, 16'hE581));
    send_item(entry_item(0, 3, kmhrb_pkg::TYPE_OTHER, 16'h1234));
    send_item(entry_item(NUM_ROWS - 1, NUM_COLS - 1, kmhrb_pkg::TYPE_HIDMOD, 16'hFFFF));
    send_item(mask_item(0, 14'h000F));
    sender_gap();
    send_item(mask_item(NUM_ROWS - 1, 14'h2000));
    send_item(build_item());
  endtask

  // Writes outside the matrix and the unused command must leave no trace;
  // later builds would show it if they did.
  task automatic test_ignored_commands();
    kmhrb_pkg::in_item_t it;
    send_item(entry_item(NUM_ROWS, 0, kmhrb_pkg::TYPE_HID, 16'h00AA));
    send_item(entry_item(7, 3, kmhrb_pkg::TYPE_MOD, 16'h00FF));
    sender_gap();
    send_item(entry_item(0, NUM_COLS, kmhrb_pkg::TYPE_HID, 16'h0055));
    send_item(entry_item(0, 15, kmhrb_pkg::TYPE_HIDMOD, 16'hFFFF));
    send_item(mask_item(7, 14'h3FFF));
    it     = random_fields();
    it.cmd = CMD_UNUSED;
    send_item(it);
    send_item(build_item());
  endtask

  // All keys down gives a saturated count of fourteen. The threshold is swept
  // over its extremes: zero always rolls over, fifteen never does, fourteen
  // just does. An empty report then checks a zero threshold alone.
  task automatic test_rollover_limits();
    logic [3:0] limits [4];
    limits = '{4'd0, 4'd15, 4'd14, 4'd1};
    for (int r = 0; r < NUM_ROWS; r++) send_item(mask_item(r, 14'h3FFF));
    foreach (limits[i]) begin
      set_rollover_limit(limits[i]);
      send_item(build_item());
    end
    for (int r = 0; r < NUM_ROWS; r++) send_item(mask_item(r, 14'h0000));
    set_rollover_limit(4'd0);
    send_item(build_item());
    set_rollover_limit(kmhrb_pkg::KEY_LIMIT_RESET);
  endtask

  // Mostly well-formed scans: a few keymap updates, a few row masks, then a
  // build. About one pass in ten sends a noise item with any command and any
  // address. The threshold moves every few dozen transactions, at which point
  // the sender also holds off until every owed report is in.
  task automatic test_random_traffic();
    int since_cfg;
    int writes;
    int masks;
    since_cfg = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (since_cfg > 60) begin
        since_cfg = 0;
        if ($urandom_range(0, 4) == 0)
          set_rollover_limit(4'($urandom_range(0, 15)));
        else
          set_rollover_limit(4'($urandom_range(1, 14)));
      end
      no_gaps = (random_sent >= RANDOM_ITEMS * 7 / 8);
      if ($urandom_range(0, 9) == 0) begin
        send_item(random_fields());
        random_sent++;
        since_cfg++;
        sender_gap();
      end else begin
        writes = $urandom_range(0, 3);
        masks  = $urandom_range(1, 3);
        repeat (writes) begin
          send_item(entry_item($urandom_range(0, NUM_ROWS - 1),
                               $urandom_range(0, NUM_COLS - 1),
                               2'($urandom_range(0, 3)), 16'($urandom)));
          sender_gap();
        end
        repeat (masks) begin
          send_item(mask_item($urandom_range(0, NUM_ROWS - 1), pick_mask()));
          sender_gap();
        end
        send_item(build_item());
        sender_gap();
        random_sent += writes + masks + 1;
        since_cfg   += writes + masks + 1;
      end
    end
  endtask

  // Each strobed slot is taken at the edge that ends its cycle and compared
  // field by field against the oldest prediction.
  always @(posedge clk) begin
    kmhrb_pkg::out_item_t exp_slot;
    if (rst_n && out_valid) begin
      if (pending_slots.size() == 0) begin
        $error("slot result with no report pending: slot_index %0d keycode %0h",
               out_item.slot_index, out_item.keycode);
        error_count++;
      end else begin
        exp_slot = pending_slots.pop_front();
        if (out_item.slot_index !== exp_slot.slot_index) begin
          $error("slot_index mismatch: expected %0d, actual %0d",
                 exp_slot.slot_index, out_item.slot_index);
          error_count++;
        end
        if (out_item.keycode !== exp_slot.keycode) begin
          $error("keycode mismatch: expected %0h, actual %0h",
                 exp_slot.keycode, out_item.keycode);
          error_count++;
        end
        if (out_item.modifier !== exp_slot.modifier) begin
          $error("modifier mismatch: expected %0h, actual %0h",
                 exp_slot.modifier, out_item.modifier);
          error_count++;
        end
        if (out_item.rollover !== exp_slot.rollover) begin
          $error("rollover mismatch: expected %0b, actual %0b",
                 exp_slot.rollover, out_item.rollover);
          error_count++;
        end
        if (out_item.last !== exp_slot.last) begin
          $error("last mismatch: expected %0b, actual %0b",
                 exp_slot.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // Main sequence. The shadow state mirrors the reset values, then the tests
  // run in turn. At the end the run waits out the last report and a full
  // build time more, so stray results are still caught.
  initial begin
    foreach (keymap_shadow[i]) keymap_shadow[i] = '0;
    foreach (row_masks[i]) row_masks[i] = '0;
    rollover_limit = kmhrb_pkg::KEY_LIMIT_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_keymap_fill();
    test_entry_types();
    test_ignored_commands();
    test_rollover_limits();
    test_random_traffic();

    wait_reports_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is a few hundred microseconds.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
